### sv/text_line_break_finder_defines.svh
// Assertion helpers for the line break finder.
`ifndef TEXT_LINE_BREAK_FINDER_DEFINES_SVH
`define TEXT_LINE_BREAK_FINDER_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define TLBF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset.
`define TLBF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/tlbf_pkg.sv
package tlbf_pkg;

    localparam int MAX_RUN_CHARS = 4096;
    localparam int GLYPH_COUNT   = 256;
    localparam int QUEUE_DEPTH   = 4;

    localparam int CODE_W  = 8;
    localparam int GLYPH_W = 8;
    localparam int LW_W    = 16;
    localparam int SUM_W   = 21;
    localparam int BRK_W   = 13;
    localparam int GADDR_W = $clog2(GLYPH_COUNT);
    localparam int POS_W   = $clog2(MAX_RUN_CHARS + 1);
    // offset may reach MAX_RUN_CHARS + 1 (break after a newline)
    localparam int OFS_W   = ($clog2(MAX_RUN_CHARS + 2) > BRK_W) ?
                             $clog2(MAX_RUN_CHARS + 2) : BRK_W;
    localparam int QA_W    = $clog2(QUEUE_DEPTH);
    localparam int QC_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_RUN_CHARS);

    localparam logic [CODE_W-1:0] CODE_TAB     = 8'd9;
    localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
    localparam logic [CODE_W-1:0] CODE_CR      = 8'd13;
    localparam logic [CODE_W-1:0] CODE_SPACE   = 8'd32;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEXT = 1'b1;

    // register word index (paddr[2])
    localparam logic REG_LINE_WIDTH = 1'b0;

    // one classified item as it sits in the queue
    typedef struct packed {
        logic               is_text;
        logic               in_range;
        logic [GADDR_W-1:0] addr;
        logic [GLYPH_W-1:0] adv;
        logic [GLYPH_W-1:0] trl;
        logic               full_line;
        logic               last;
        logic               blank;
        logic               newline;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic is_blank(input logic [CODE_W-1:0] code);
        return (code == CODE_SPACE) || ((code >= CODE_TAB) && (code <= CODE_CR));
    endfunction

endpackage

### sv/text_line_break_finder.sv
// Greedy word wrap: finds where the next line of a text run begins.
// Input stream (s_axis_*): tuser selects the item kind. A load item writes
// the advance and trailing widths of one glyph; a text item carries one
// character, tlast marking the final character of the run. full_line is
// sampled on the first character of each run.
// Output stream (m_axis_*): one item per run, the break offset and a flag
// set when the whole run fits. Characters after the break are swallowed.
// APB port: line_width at address 0; write only while the block is idle.
// Throughput: one item per cycle while the receiver keeps up, limited by
// the single glyph table port and the width accumulate and compare loop
// in the back end. An accepted item is written into the queue, its glyph
// entry is read, and the decision is registered into the output register.
// Receiver stall: the output register holds; the back end stops, and the
// four-entry queue keeps taking items until full, then drops s_axis_tready.
// Reset (synchronous, active low): clears run state, queue and line_width.
// Glyph tables are not cleared; load an entry before it is used.
`include "text_line_break_finder_defines.svh"

module text_line_break_finder import tlbf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] char_code, [15:8] glyph_advance, [23:16] glyph_trailing,
    // [24] full_line, [31:25] zero
    input  logic [31:0] s_axis_tdata,
    // [0] cmd
    input  logic        s_axis_tuser,
    // final character of the run
    input  logic        s_axis_tlast,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [12:0] break_offset, [13] reached_end, [15:14] zero
    output logic [15:0] m_axis_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [LW_W-1:0] r_line_width;
    logic            cfg_wr;

    logic            push;
    logic            pop;
    t_item           in_item;
    t_item           head;
    t_q_stat         q_stat;

    // -- configuration register --
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= '0;
        end else if (cfg_wr && (paddr[2] == REG_LINE_WIDTH)) begin
            r_line_width <= pwdata[LW_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_LINE_WIDTH) ? 32'(r_line_width) : '0;

    // -- front end: accept and classify --
    tlbf_front u_front (
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_tlast  (s_axis_tlast),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_item   (in_item)
    );

    // -- decoupling queue --
    tlbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (in_item),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // -- back end: table access, measuring, break decision --
    tlbf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line_width (r_line_width),
        .i_head       (head),
        .i_q_stat     (q_stat),
        .o_pop        (pop),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_tdata      (m_axis_tdata)
    );

    // -- checks --
    `TLBF_ASSERT_IMP(a_q_stat_sane, q_stat.full, !q_stat.empty, "queue both full and empty")
    `TLBF_ASSERT_IMP(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")
    `TLBF_ASSERT_IMP(a_end_nonzero, m_axis_tvalid && m_axis_tdata[13],
                     m_axis_tdata[12:0] != 13'd0, "run end reported at offset zero")

endmodule

### sv/tlbf_ram.sv
module tlbf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/tlbf_front.sv
module tlbf_front import tlbf_pkg::*; (
    input  logic        i_tvalid,
    output logic        o_tready,
    // [7:0] char_code, [15:8] glyph_advance, [23:16] glyph_trailing, [24] full_line
    input  logic [31:0] i_tdata,
    // [0] cmd
    input  logic        i_tuser,
    input  logic        i_tlast,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_item       o_item
);

    logic [CODE_W-1:0] code;

    assign code     = i_tdata[7:0];
    assign o_tready = !i_q_stat.full;
    assign o_push   = i_tvalid && !i_q_stat.full;

    always_comb begin
        o_item.is_text   = (i_tuser == CMD_TEXT);
        o_item.in_range  = (int'(code) < GLYPH_COUNT);
        o_item.addr      = code[GADDR_W-1:0];
        o_item.adv       = i_tdata[15:8];
        o_item.trl       = i_tdata[23:16];
        o_item.full_line = i_tdata[24];
        o_item.last      = i_tlast;
        o_item.blank     = is_blank(code);
        o_item.newline   = (code == CODE_NEWLINE);
    end

endmodule

### sv/tlbf_queue.sv
module tlbf_queue import tlbf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output t_item   o_head,
    output t_q_stat o_stat
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QA_W-1:0]   r_wr_ptr;
    logic [QA_W-1:0]   r_rd_ptr;
    logic [QC_W-1:0]   r_count;

    function automatic logic [QA_W-1:0] ptr_inc(input logic [QA_W-1:0] p);
        return (p == QA_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == QC_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

### sv/tlbf_back.sv
module tlbf_back import tlbf_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [LW_W-1:0] i_line_width,
    input  t_item           i_head,
    input  t_q_stat         i_q_stat,
    output logic            o_pop,
    output logic            o_tvalid,
    input  logic            i_tready,
    // [12:0] break_offset, [13] reached_end
    output logic [15:0]     o_tdata
);

    // stage A: pop and table access; stage B: measure and decide
    logic                     a_go;
    logic                     b_fire;
    logic                     ram_we;
    logic                     ram_re;
    logic [2*GLYPH_W-1:0]     ram_rdata;

    logic                     r_b_valid;
    t_item                    r_b_item;

    logic [SUM_W-1:0]         r_width_sum, n_width_sum;
    logic [POS_W-1:0]         r_word_begin, n_word_begin;
    logic [POS_W-1:0]         r_char_pos, n_char_pos;
    logic                     r_prev_space, n_prev_space;
    logic                     r_run_done, n_run_done;
    logic                     r_fresh, n_fresh;

    logic                     r_o_valid;
    logic [BRK_W-1:0]         r_o_offset;
    logic                     r_o_end;

    logic [GLYPH_W-1:0]       adv;
    logic [GLYPH_W-1:0]       trl;
    logic [SUM_W:0]           sum_ext;
    logic [SUM_W-1:0]         sum_sat;
    logic [SUM_W:0]           limit;
    logic                     fresh;
    logic [POS_W-1:0]         wb;
    logic [POS_W-1:0]         pos_next;
    logic                     ovf;
    logic                     brk;
    logic [OFS_W-1:0]         brk_ofs;
    logic                     res_valid;
    logic [OFS_W-1:0]         res_ofs;
    logic                     res_end;

    assign b_fire = r_b_valid && (!r_o_valid || i_tready);
    assign a_go   = !r_b_valid || b_fire;
    assign o_pop  = a_go && !i_q_stat.empty;
    assign ram_we = o_pop && !i_head.is_text && i_head.in_range;
    assign ram_re = o_pop && i_head.is_text;

    tlbf_ram #(
        .WIDTH (2 * GLYPH_W),
        .DEPTH (GLYPH_COUNT)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (i_head.addr),
        .i_wdata ({i_head.trl, i_head.adv}),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_go) begin
            r_b_valid <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_item <= i_head;
        end
    end

    // out-of-range codes read as zero width
    assign adv = r_b_item.in_range ? ram_rdata[GLYPH_W-1:0] : '0;
    assign trl = r_b_item.in_range ? ram_rdata[2*GLYPH_W-1:GLYPH_W] : '0;

    always_comb begin
        fresh    = (r_char_pos == '0) ? r_b_item.full_line : r_fresh;
        wb       = (r_prev_space && !r_b_item.blank) ? r_char_pos : r_word_begin;
        sum_ext  = (SUM_W+1)'(r_width_sum) + (SUM_W+1)'(adv);
        sum_sat  = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
        limit    = (SUM_W+1)'(i_line_width) + (SUM_W+1)'(trl);
        ovf      = ({1'b0, sum_sat} > limit) && (r_prev_space || !r_b_item.blank);
        pos_next = (r_char_pos < MAX_POS) ? r_char_pos + 1'b1 : r_char_pos;
        brk      = r_b_item.newline || ovf;

        if (r_b_item.newline) begin
            brk_ofs = OFS_W'(r_char_pos) + 1'b1;
        end else if ((wb != '0) || !fresh) begin
            brk_ofs = OFS_W'(wb);
        end else if (r_char_pos != '0) begin
            brk_ofs = OFS_W'(r_char_pos);
        end else begin
            brk_ofs = OFS_W'(1);
        end

        n_width_sum  = r_width_sum;
        n_word_begin = r_word_begin;
        n_char_pos   = r_char_pos;
        n_prev_space = r_prev_space;
        n_run_done   = r_run_done;
        n_fresh      = r_fresh;
        res_valid    = 1'b0;
        res_ofs      = OFS_W'(pos_next);
        res_end      = 1'b1;

        if (r_b_item.is_text) begin
            if (r_run_done) begin
                // tail of a run already broken: swallow
            end else begin
                n_width_sum  = sum_sat;
                n_word_begin = wb;
                n_char_pos   = pos_next;
                n_prev_space = r_b_item.blank;
                n_fresh      = fresh;
                if (brk) begin
                    res_valid  = 1'b1;
                    res_ofs    = brk_ofs;
                    res_end    = r_b_item.last && (brk_ofs == OFS_W'(pos_next));
                    n_run_done = 1'b1;
                end else if (r_b_item.last) begin
                    res_valid = 1'b1;
                end
            end
            if (r_b_item.last) begin
                n_width_sum  = '0;
                n_word_begin = '0;
                n_char_pos   = '0;
                n_prev_space = 1'b0;
                n_run_done   = 1'b0;
                n_fresh      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_sum  <= '0;
            r_word_begin <= '0;
            r_char_pos   <= '0;
            r_prev_space <= 1'b0;
            r_run_done   <= 1'b0;
            r_fresh      <= 1'b0;
        end else if (b_fire) begin
            r_width_sum  <= n_width_sum;
            r_word_begin <= n_word_begin;
            r_char_pos   <= n_char_pos;
            r_prev_space <= n_prev_space;
            r_run_done   <= n_run_done;
            r_fresh      <= n_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (b_fire && res_valid) begin
            r_o_valid <= 1'b1;
        end else if (i_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fire && res_valid) begin
            r_o_offset <= res_ofs[BRK_W-1:0];
            r_o_end    <= res_end;
        end
    end

    assign o_tvalid = r_o_valid;
    assign o_tdata  = {(16 - BRK_W - 1)'(0), r_o_end, r_o_offset};

endmodule

### tb/tb_text_line_break_finder.sv
`timescale 1ns / 100ps

module tb_text_line_break_finder;
    import tlbf_pkg::*;

    // Character codes used by the directed part
    localparam logic [CODE_W-1:0] CODE_NUL      = 8'd0;
    localparam logic [CODE_W-1:0] CODE_LETTER_A = 8'd97;
    localparam logic [CODE_W-1:0] CODE_HIGH     = 8'd255;

    // Cycles the block may still be busy with items that give no result
    localparam int DRAIN_CYCLES = 32;
    // Random items per line width setting
    localparam int ITEMS_PER_SETTING = 70;
    localparam int MAX_REPORTS = 100;

    // One input item, as the stream carries it
    typedef struct packed {
        logic               cmd;
        logic [CODE_W-1:0]  code;
        logic [GLYPH_W-1:0] adv;
        logic [GLYPH_W-1:0] trl;
        logic               full_line;
        logic               last;
    } t_wrap_item;

    // One expected break
    typedef struct packed {
        logic [BRK_W-1:0] offset;
        logic             reached_end;
    } t_line_break;

    // Greedy wrap predictor: its own copy of the glyph tables, the line
    // width and the run state, and the breaks still to come from the block.
    class wrap_scoreboard;
        logic [LW_W-1:0]    line_width;
        logic [GLYPH_W-1:0] adv_tab [GLYPH_COUNT];
        logic [GLYPH_W-1:0] trl_tab [GLYPH_COUNT];
        int unsigned        width_sum;
        int unsigned        held_trl;
        int unsigned        word_pos;
        int unsigned        char_pos;
        bit                 prev_blank;
        bit                 broken;
        bit                 fresh;
        t_line_break        breaks_due [$];
        int                 errors;

        function new();
            line_width = '0;
            errors     = 0;
            clear_run();
        endfunction

        function void clear_run();
            width_sum  = 0;
            held_trl   = 0;
            word_pos   = 0;
            char_pos   = 0;
            prev_blank = 1'b0;
            broken     = 1'b0;
            fresh      = 1'b0;
        endfunction

        task report(string msg);
            if (errors < MAX_REPORTS)
                $display("%0t ns: mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // Accepted input item: update tables or run state, queue any break
        function void note_item(t_wrap_item it);
            bit          blank;
            bit          brk;
            int unsigned offset;
            int unsigned a;
            int unsigned t;
            t_line_break lb;
            brk    = 1'b0;
            offset = 0;
            if (it.cmd == CMD_LOAD) begin
                if (it.code < GLYPH_COUNT) begin
                    adv_tab[it.code] = it.adv;
                    trl_tab[it.code] = it.trl;
                end
                return;
            end
            // swallow the rest of a run once its break has gone out
            if (broken) begin
                if (it.last)
                    clear_run();
                return;
            end
            if (char_pos == 0)
                fresh = it.full_line;
            blank = (it.code == CODE_SPACE) ||
                    ((it.code >= CODE_TAB) && (it.code <= CODE_CR));
            if (prev_blank && !blank)
                word_pos = char_pos;
            a = (it.code < GLYPH_COUNT) ? int'(adv_tab[it.code]) : 0;
            t = (it.code < GLYPH_COUNT) ? int'(trl_tab[it.code]) : 0;
            width_sum += a;
            if (width_sum > SUM_MAX)
                width_sum = SUM_MAX;
            if (it.code == CODE_NEWLINE) begin
                brk    = 1'b1;
                offset = char_pos + 1;
            end else if (width_sum > int'(line_width) + t && (prev_blank || !blank)) begin
                // overflow: back to the word start, except a single word
                // filling a fresh line, which is split here
                brk = 1'b1;
                if (word_pos > 0 || !fresh)
                    offset = word_pos;
                else
                    offset = (char_pos > 0) ? char_pos : 1;
            end
            prev_blank = blank;
            held_trl   = t;
            if (char_pos < MAX_RUN_CHARS)
                char_pos++;
            if (brk) begin
                lb.offset      = offset[BRK_W-1:0];
                lb.reached_end = it.last && (offset == char_pos);
                breaks_due.push_back(lb);
                if (it.last)
                    clear_run();
                else
                    broken = 1'b1;
            end else if (it.last) begin
                lb.offset      = char_pos[BRK_W-1:0];
                lb.reached_end = 1'b1;
                breaks_due.push_back(lb);
                clear_run();
            end
        endfunction

        // Accepted result: compare with the oldest expected break
        task check_break(logic [15:0] data);
            t_line_break lb;
            if (breaks_due.size() == 0) begin
                report($sformatf("unexpected result %h", data));
                return;
            end
            lb = breaks_due.pop_front();
            if (data[BRK_W-1:0] !== lb.offset)
                report($sformatf("break_offset %0d, expected %0d",
                                 data[BRK_W-1:0], lb.offset));
            if (data[BRK_W] !== lb.reached_end)
                report($sformatf("reached_end %b, expected %b",
                                 data[BRK_W], lb.reached_end));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    wrap_scoreboard sb;

    // sender burst state
    int burst_left = 0;
    // receiver stall pattern state
    int rx_mode    = 0;
    int rx_count   = 0;

    text_line_break_finder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: switches between free flow, random and blocky stalls
    always @(posedge i_clk) begin
        if (rx_count == 0) begin
            rx_mode  <= $urandom_range(0, 3);
            rx_count <= $urandom_range(16, 96);
        end else begin
            rx_count <= rx_count - 1;
        end
        unique case (rx_mode)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_axis_tready <= ($urandom_range(0, 7) != 0);
            end
            default: begin
                // long stalls: ready only while rx_count % 16 is above 11
                m_axis_tready <= ((rx_count % 16) > 11);
            end
        endcase
    end

    // Input monitor: every accepted item goes to the predictor
    always @(posedge i_clk) begin
        t_wrap_item it;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            it.cmd       = s_axis_tuser;
            it.code      = s_axis_tdata[7:0];
            it.adv       = s_axis_tdata[15:8];
            it.trl       = s_axis_tdata[23:16];
            it.full_line = s_axis_tdata[24];
            it.last      = s_axis_tlast;
            sb.note_item(it);
        end
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_break(m_axis_tdata);
    end

    function automatic t_wrap_item text_item(logic [CODE_W-1:0] code, logic full, logic last);
        t_wrap_item it;
        it.cmd       = CMD_TEXT;
        it.code      = code;
        it.adv       = GLYPH_W'($urandom_range(0, 255));
        it.trl       = GLYPH_W'($urandom_range(0, 255));
        it.full_line = full;
        it.last      = last;
        return it;
    endfunction

    function automatic t_wrap_item load_item(logic [CODE_W-1:0] code,
                                             logic [GLYPH_W-1:0] adv,
                                             logic [GLYPH_W-1:0] trl);
        t_wrap_item it;
        it.cmd       = CMD_LOAD;
        it.code      = code;
        it.adv       = adv;
        it.trl       = trl;
        it.full_line = 1'($urandom_range(0, 1));
        it.last      = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Random character: mostly printable, some blanks, newlines and high codes
    function automatic logic [CODE_W-1:0] pick_char();
        unique case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return CODE_W'($urandom_range(33, 126));
            5, 6:          return CODE_SPACE;
            7:             return CODE_W'($urandom_range(CODE_TAB, CODE_CR));
            8:             return CODE_W'($urandom_range(128, 255));
            default:       return CODE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Random load item for any table entry
    function automatic t_wrap_item random_load();
        return load_item(CODE_W'($urandom_range(0, 255)),
                         GLYPH_W'($urandom_range(0, 255)),
                         GLYPH_W'($urandom_range(0, 255)));
    endfunction

    // Sends one item; called just after a rising edge, returns at the
    // edge where the item is taken. Gaps fall between random bursts.
    task automatic send_item(t_wrap_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tdata  <= {7'b0, it.full_line, it.trl, it.adv, it.code};
        s_axis_tuser  <= it.cmd;
        s_axis_tlast  <= it.last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop sending, let every expected break arrive, then let the queue
    // drain items that give no result
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.breaks_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup then access, register taken when pready is high
    task automatic write_line_width(logic [LW_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_LINE_WIDTH, 2'b00};
        pwdata  <= {16'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.line_width = value;
    endtask

    // One well-formed run with random content, loads now and then inside it
    task automatic send_run(int len);
        for (int i = 0; i < len; i++) begin
            if (i > 0 && $urandom_range(0, 19) == 0)
                send_item(random_load());
            send_item(text_item(pick_char(), 1'($urandom_range(0, 1)), i == len - 1));
        end
    endtask

    initial begin
        int sent;
        int len;
        logic [LW_W-1:0] lw;
        sb = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_LOAD;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill both tables so no later read finds an unwritten entry
        for (int c = 0; c < GLYPH_COUNT; c++)
            send_item(load_item(CODE_W'(c), GLYPH_W'($urandom_range(0, 255)),
                                GLYPH_W'($urandom_range(0, 255))));

        // Directed: known widths for a handful of glyphs
        send_item(load_item(CODE_LETTER_A, 8'd10, 8'd2));
        send_item(load_item(CODE_SPACE, 8'd4, 8'd4));
        send_item(load_item(CODE_NEWLINE, 8'd0, 8'd0));
        send_item(load_item(CODE_HIGH, 8'hFF, 8'hFF));
        send_item(load_item(CODE_NUL, 8'd0, 8'd0));
        wait_idle();

        // zero width: a lone word on a fresh line splits after one char,
        // otherwise it goes whole to the next line; zero-width glyphs fit
        write_line_width('0);
        send_item(text_item(CODE_LETTER_A, 1'b1, 1'b1));
        send_item(text_item(CODE_LETTER_A, 1'b0, 1'b1));
        send_item(text_item(CODE_NUL, 1'b1, 1'b0));
        send_item(text_item(CODE_NUL, 1'b0, 1'b1));
        wait_idle();

        // widest line: break after a newline, rest of the run swallowed
        write_line_width('1);
        send_item(text_item(CODE_LETTER_A, 1'b0, 1'b0));
        send_item(text_item(CODE_SPACE, 1'b0, 1'b0));
        send_item(text_item(CODE_LETTER_A, 1'b0, 1'b0));
        send_item(text_item(CODE_NEWLINE, 1'b0, 1'b0));
        send_item(text_item(CODE_LETTER_A, 1'b0, 1'b1));
        send_item(text_item(CODE_HIGH, 1'b1, 1'b0));
        send_item(text_item(CODE_SPACE, 1'b0, 1'b0));
        send_item(text_item(CODE_HIGH, 1'b0, 1'b1));
        wait_idle();

        // overflow at the start of the second word
        write_line_width(16'd15);
        send_item(text_item(CODE_LETTER_A, 1'b1, 1'b0));
        send_item(text_item(CODE_SPACE, 1'b0, 1'b0));
        send_item(text_item(CODE_LETTER_A, 1'b0, 1'b1));
        wait_idle();

        // Random runs under a series of line widths
        for (int ph = 0; ph < 6; ph++) begin
            unique case (ph)
                0:       lw = '1;
                1:       lw = '0;
                4:       lw = LW_W'($urandom_range(0, 65535));
                5:       lw = LW_W'($urandom_range(100, 600));
                default: lw = LW_W'($urandom_range(100, 3000));
            endcase
            write_line_width(lw);
            sent = 0;
            while (sent < ITEMS_PER_SETTING) begin
                if ($urandom_range(0, 7) == 0) begin
                    // stray load between runs
                    send_item(random_load());
                    sent++;
                end else begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                      : $urandom_range(1, 30);
                    send_run(len);
                    sent += len;
                end
            end
            wait_idle();
        end

        if (sb.errors == 0)
            $display("text_line_break_finder regression: pass");
        else
            $display("text_line_break_finder regression: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("text_line_break_finder regression: fail");
        $finish;
    end

endmodule

### text_line_break_finder.f
+incdir+sv
sv/tlbf_pkg.sv
sv/tlbf_ram.sv
sv/tlbf_front.sv
sv/tlbf_queue.sv
sv/tlbf_back.sv
sv/text_line_break_finder.sv
tb/tb_text_line_break_finder.sv
